>>> design/sawl_pkg.sv
// Shared types and constants for the stop-and-wait ARQ link core
package sawl_pkg;

  localparam int MemoEntriesDef = 8;
  localparam int HeaderBytesDef = 6;

  localparam logic [15:0] IdMax       = 16'hFFFF;
  localparam logic [15:0] IdSeedRst   = 16'd10000;
  localparam logic [3:0]  RetryRst    = 4'd3;
  localparam logic [15:0] AckTmoRst   = 16'd100;
  localparam logic [15:0] MemoLifeRst = 16'd5000;
  localparam logic [7:0]  MaxLenRst   = 8'd200;

  typedef enum logic [2:0] {
    REQ_SEND = 3'd0, REQ_PING = 3'd1, REQ_RADIO = 3'd2, REQ_RX = 3'd3, REQ_TICK = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    KIND_MSG = 2'd0, KIND_ACK = 2'd1, KIND_PING = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ACT_TX_MSG = 4'd0, ACT_TX_ACK = 4'd1, ACT_TX_PING = 4'd2, ACT_DELIVER = 4'd3,
    ACT_PING_SEEN = 4'd4, ACT_SEND_OK = 4'd5, ACT_SEND_FAIL = 4'd6,
    ACT_REJECT = 4'd7, ACT_DROP = 4'd8
  } act_t;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_TX_MSG, MODE_WAIT_ACK, MODE_TX_ACK, MODE_TX_PING
  } mode_t;

  typedef enum logic [2:0] {
    ADDR_PEER = 3'd0, ADDR_RETRY = 3'd1, ADDR_ACK_TMO = 3'd2,
    ADDR_MEMO_LIFE = 3'd3, ADDR_MAX_LEN = 3'd4, ADDR_ID_SEED = 3'd5
  } reg_addr_t;

  // classified request handed from front to back
  typedef struct packed {
    req_t        req;
    logic        len_ok;
    logic        src_ok;
    logic        hdr_ok;
    logic        exact_ok;
    logic        crc_ok;
    logic        radio_ok;
    kind_t       kind;
    logic [15:0] rx_id;
    logic [7:0]  rx_size;
    logic [7:0]  plen;
    logic [15:0] pcrc;
  } cmd_t;

  typedef struct packed {
    act_t        action;
    logic [15:0] pkt_id;
    logic [7:0]  pkt_len;
    logic [15:0] pkt_checksum;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [47:0] peer_address;
    logic [3:0]  retry_limit;
    logic [15:0] ack_timeout_ms;
    logic [15:0] memo_lifetime_ms;
    logic [7:0]  max_payload_len;
  } cfg_t;

endpackage

>>> design/sawl_front.sv
// Front end: accepts requests, runs the stateless checks, queues commands
module sawl_front import sawl_pkg::*; #(
  parameter int HeaderBytes = HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_payload_len,
  input  logic [15:0] in_payload_crc,
  input  logic        in_radio_ok,
  input  logic [47:0] in_source_address,
  input  logic [7:0]  in_received_len,
  input  logic [1:0]  in_rx_kind,
  input  logic [15:0] in_rx_id,
  input  logic [7:0]  in_rx_payload_size,
  input  logic [15:0] in_rx_checksum,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [8:0] HdrLen = 9'(HeaderBytes);

  // two-entry queue
  cmd_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t c;
  logic push, pop;

  always_comb begin
    c.req      = req_t'(in_req_type);
    c.len_ok   = in_payload_len <= cfg.max_payload_len;
    c.src_ok   = in_source_address == cfg.peer_address;
    c.hdr_ok   = {1'b0, in_received_len} >= HdrLen;
    c.exact_ok = {1'b0, in_received_len} == HdrLen + {1'b0, in_rx_payload_size};
    c.crc_ok   = in_payload_crc == in_rx_checksum;
    c.radio_ok = in_radio_ok;
    c.kind     = kind_t'(in_rx_kind);
    c.rx_id    = in_rx_id;
    c.rx_size  = in_rx_payload_size;
    c.plen     = in_payload_len;
    c.pcrc     = in_payload_crc;
  end

  assign in_ready  = cnt_r != 2'd2;
  assign push      = in_valid && in_ready;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= c;
        wp_r      <= ~wp_r;
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/sawl_back.sv
// Back end: link state machine, memo ring scan and result register
module sawl_back import sawl_pkg::*; #(
  parameter int MemoEntries = MemoEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        seed_we,
  input  logic [15:0] seed_val,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        res
);

  localparam int MW = (MemoEntries > 1) ? $clog2(MemoEntries) : 1;
  localparam int CW = $clog2(MemoEntries + 1);
  localparam logic [CW-1:0] NEnt = CW'(MemoEntries);
  localparam logic [MW-1:0] LastSlot = MW'(MemoEntries - 1);

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_OUT1, B_OUT2} bst_t;

  bst_t bst_r, bst_nxt;
  mode_t mode_r, mode_nxt;
  logic [15:0] nid_r, nid_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [15:0] wt_r, wt_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] oid_r, oid_nxt;
  logic [7:0]  olen_r, olen_nxt;
  logic [15:0] ochk_r, ochk_nxt;
  logic [MW-1:0] ws_r, ws_nxt;
  logic [CW-1:0] sc_r, sc_nxt;
  logic hit_r, hit_nxt;
  cmd_t cur_r, cur_nxt;
  res_t r1_r, r1_nxt, r2_r, r2_nxt;

  logic [MemoEntries-1:0] mv_r;
  logic [15:0] mid_r [MemoEntries];
  logic [31:0] mst_r [MemoEntries];
  logic        mem_we;

  logic [MW-1:0] si;
  logic [31:0] age;
  logic ent_hit;
  logic [15:0] inc_id, wt_inc;

  assign si      = sc_r[MW-1:0];
  assign age     = now_r - mst_r[si];
  assign ent_hit = mv_r[si] && (age < {16'd0, cfg.memo_lifetime_ms}) &&
                   (mid_r[si] == cur_r.rx_id);
  assign inc_id  = (nid_r == IdMax) ? 16'd1 : nid_r + 16'd1;
  assign wt_inc  = wt_r + 16'd1;
  assign cmd_ready = bst_r == B_IDLE;
  assign out_valid = bst_r == B_OUT1 || bst_r == B_OUT2;
  assign res       = (bst_r == B_OUT2) ? r2_r : r1_r;

  function automatic res_t mk(act_t a, logic [15:0] id, logic [7:0] l, logic [15:0] k,
                              logic lst);
    res_t t;
    t.action = a; t.pkt_id = id; t.pkt_len = l; t.pkt_checksum = k; t.last = lst;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r <= B_IDLE; mode_r <= MODE_IDLE; nid_r <= IdSeedRst; att_r <= '0;
      wt_r <= '0; now_r <= '0; oid_r <= '0; olen_r <= '0; ochk_r <= '0;
      ws_r <= '0; sc_r <= '0; hit_r <= 1'b0; mv_r <= '0;
    end else begin
      bst_r <= bst_nxt; mode_r <= mode_nxt; nid_r <= seed_we ? seed_val : nid_nxt;
      att_r <= att_nxt; wt_r <= wt_nxt; now_r <= now_nxt; oid_r <= oid_nxt;
      olen_r <= olen_nxt; ochk_r <= ochk_nxt; ws_r <= ws_nxt; sc_r <= sc_nxt;
      hit_r <= hit_nxt;
      if (mem_we) mv_r[ws_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
    if (mem_we) begin
      mid_r[ws_r] <= cur_r.rx_id;
      mst_r[ws_r] <= now_r;
    end
  end

  always_comb begin
    bst_nxt = bst_r; mode_nxt = mode_r; nid_nxt = nid_r; att_nxt = att_r;
    wt_nxt = wt_r; now_nxt = now_r; oid_nxt = oid_r; olen_nxt = olen_r;
    ochk_nxt = ochk_r; ws_nxt = ws_r; sc_nxt = sc_r; hit_nxt = hit_r;
    cur_nxt = cur_r; r1_nxt = r1_r; r2_nxt = r2_r; mem_we = 1'b0;
    unique case (bst_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          r1_nxt  = mk(ACT_DROP, '0, '0, '0, 1'b1);
          bst_nxt = B_OUT1;
          unique case (cmd.req)
            REQ_SEND: begin
              if (mode_r != MODE_IDLE || !cmd.len_ok) begin
                r1_nxt = mk(ACT_REJECT, '0, '0, '0, 1'b1);
              end else begin
                nid_nxt = inc_id; oid_nxt = inc_id; olen_nxt = cmd.plen;
                ochk_nxt = cmd.pcrc; att_nxt = '0; mode_nxt = MODE_TX_MSG;
                r1_nxt = mk(ACT_TX_MSG, inc_id, cmd.plen, cmd.pcrc, 1'b1);
              end
            end
            REQ_PING: begin
              if (mode_r != MODE_IDLE) begin
                r1_nxt = mk(ACT_REJECT, '0, '0, '0, 1'b1);
              end else begin
                mode_nxt = MODE_TX_PING;
                r1_nxt = mk(ACT_TX_PING, '0, '0, '0, 1'b1);
              end
            end
            REQ_RADIO: begin
              bst_nxt = B_IDLE;
              if (mode_r == MODE_TX_MSG) begin
                if (cmd.radio_ok) begin
                  mode_nxt = MODE_WAIT_ACK; wt_nxt = '0;
                end else begin
                  mode_nxt = MODE_IDLE;
                  r1_nxt = mk(ACT_SEND_FAIL, oid_r, '0, '0, 1'b1);
                  bst_nxt = B_OUT1;
                end
              end else if (mode_r == MODE_TX_ACK || mode_r == MODE_TX_PING) begin
                mode_nxt = MODE_IDLE;
              end
            end
            REQ_RX: begin
              if (!cmd.src_ok) begin
                // dropped
              end else if (mode_r == MODE_WAIT_ACK) begin
                if (cmd.hdr_ok && cmd.kind == KIND_ACK && cmd.rx_id == oid_r) begin
                  mode_nxt = MODE_IDLE;
                  r1_nxt = mk(ACT_SEND_OK, oid_r, '0, '0, 1'b1);
                end
              end else if (mode_r != MODE_IDLE || !cmd.hdr_ok) begin
                // dropped
              end else if (cmd.kind == KIND_PING) begin
                r1_nxt = mk(ACT_PING_SEEN, '0, '0, '0, 1'b1);
              end else if (cmd.kind == KIND_MSG && cmd.exact_ok && cmd.crc_ok) begin
                mode_nxt = MODE_TX_ACK;
                sc_nxt = '0; hit_nxt = 1'b0;
                bst_nxt = B_SCAN;
              end
            end
            REQ_TICK: begin
              bst_nxt = B_IDLE;
              now_nxt = now_r + 32'd1;
              if (mode_r == MODE_WAIT_ACK) begin
                wt_nxt = wt_inc;
                if (wt_inc >= cfg.ack_timeout_ms) begin
                  wt_nxt = '0;
                  bst_nxt = B_OUT1;
                  if (att_r < cfg.retry_limit) begin
                    att_nxt = att_r + 4'd1; mode_nxt = MODE_TX_MSG;
                    r1_nxt = mk(ACT_TX_MSG, oid_r, olen_r, ochk_r, 1'b1);
                  end else begin
                    mode_nxt = MODE_IDLE;
                    r1_nxt = mk(ACT_SEND_FAIL, oid_r, '0, '0, 1'b1);
                  end
                end
              end
            end
            default: bst_nxt = B_IDLE;
          endcase
        end
      end
      B_SCAN: begin
        if (sc_r == NEnt) begin
          r1_nxt = mk(ACT_TX_ACK, cur_r.rx_id, '0, '0, hit_r);
          r2_nxt = mk(ACT_DELIVER, cur_r.rx_id, cur_r.rx_size, '0, 1'b1);
          if (!hit_r) begin
            mem_we = 1'b1;
            ws_nxt = (ws_r == LastSlot) ? '0 : ws_r + 1'b1;
          end
          bst_nxt = B_OUT1;
        end else begin
          hit_nxt = hit_r | ent_hit;
          sc_nxt = sc_r + 1'b1;
        end
      end
      B_OUT1: if (out_ready) bst_nxt = r1_r.last ? B_IDLE : B_OUT2;
      B_OUT2: if (out_ready) bst_nxt = B_IDLE;
      default: bst_nxt = B_IDLE;
    endcase
  end

endmodule

>>> design/sawl_regs.sv
// APB-style configuration registers
module sawl_regs import sawl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg,
  output logic        seed_we,
  output logic [15:0] seed_val
);

  cfg_t cfg_r;
  logic [15:0] seed_r;
  logic we;
  reg_addr_t ra;

  assign pready   = 1'b1;
  assign we       = psel && penable && pwrite;
  assign ra       = reg_addr_t'(paddr[5:3]);
  assign cfg      = cfg_r;
  assign seed_we  = we && paddr[2:0] == 3'd0 && ra == ADDR_ID_SEED;
  assign seed_val = pwdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peer_address     <= '0;
      cfg_r.retry_limit      <= RetryRst;
      cfg_r.ack_timeout_ms   <= AckTmoRst;
      cfg_r.memo_lifetime_ms <= MemoLifeRst;
      cfg_r.max_payload_len  <= MaxLenRst;
      seed_r                 <= IdSeedRst;
    end else if (we && paddr[2:0] == 3'd0) begin
      case (ra)
        ADDR_PEER:      cfg_r.peer_address     <= pwdata[47:0];
        ADDR_RETRY:     cfg_r.retry_limit      <= pwdata[3:0];
        ADDR_ACK_TMO:   cfg_r.ack_timeout_ms   <= pwdata[15:0];
        ADDR_MEMO_LIFE: cfg_r.memo_lifetime_ms <= pwdata[15:0];
        ADDR_MAX_LEN:   cfg_r.max_payload_len  <= pwdata[7:0];
        ADDR_ID_SEED:   seed_r                 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (ra)
      ADDR_PEER:      prdata = {16'd0, cfg_r.peer_address};
      ADDR_RETRY:     prdata = {60'd0, cfg_r.retry_limit};
      ADDR_ACK_TMO:   prdata = {48'd0, cfg_r.ack_timeout_ms};
      ADDR_MEMO_LIFE: prdata = {48'd0, cfg_r.memo_lifetime_ms};
      ADDR_MAX_LEN:   prdata = {56'd0, cfg_r.max_payload_len};
      ADDR_ID_SEED:   prdata = {48'd0, seed_r};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> design/stop_and_wait_arq_link_core.sv
// Top level of the stop-and-wait ARQ link core
//
//  Channel | Direction | Handshake            | Contents
//  in_     | in        | in_valid / in_ready  | one request (send, ping, radio, rx, tick)
//  out_    | out       | out_valid / out_ready| one result action, last marks final
//  cfg_    | in        | APB write/read       | six registers at 8-byte spacing
//
// A request is registered in the front queue before the back end takes it, and each result
// is registered in the back end and holds the output until out_ready takes it.
// A received message stays longer in the back end while the single comparator steps
// through every entry of the memo ring in turn.
// The front queue holds two classified requests, so input is taken while results wait.
// Reset is synchronous; memo valid bits clear at once, so no clearing pass is run.
module stop_and_wait_arq_link_core import sawl_pkg::*; #(
  parameter int MEMO_ENTRIES = MemoEntriesDef,
  parameter int HEADER_BYTES = HeaderBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_payload_len,
  input  logic [15:0] in_payload_crc,
  input  logic        in_radio_ok,
  input  logic [47:0] in_source_address,
  input  logic [7:0]  in_received_len,
  input  logic [1:0]  in_rx_kind,
  input  logic [15:0] in_rx_id,
  input  logic [7:0]  in_rx_payload_size,
  input  logic [15:0] in_rx_checksum,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_action,
  output logic [15:0] out_pkt_id,
  output logic [7:0]  out_pkt_len,
  output logic [15:0] out_pkt_checksum,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic seed_we;
  logic [15:0] seed_val;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  sawl_regs u_regs (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .seed_we, .seed_val
  );

  sawl_front #(.HeaderBytes(HEADER_BYTES)) u_front (
    .clk, .rst_n, .cfg, .in_valid, .in_ready, .in_req_type, .in_payload_len,
    .in_payload_crc, .in_radio_ok, .in_source_address, .in_received_len, .in_rx_kind,
    .in_rx_id, .in_rx_payload_size, .in_rx_checksum, .cmd_valid, .cmd_ready, .cmd
  );

  sawl_back #(.MemoEntries(MEMO_ENTRIES)) u_back (
    .clk, .rst_n, .cfg, .seed_we, .seed_val, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .res
  );

  assign out_action       = res.action;
  assign out_pkt_id       = res.pkt_id;
  assign out_pkt_len      = res.pkt_len;
  assign out_pkt_checksum = res.pkt_checksum;
  assign out_last         = res.last;

endmodule

>>> test/stop_and_wait_arq_link_core_test.sv
// Testbench for the stop-and-wait ARQ link core: directed table, then random requests
`timescale 1ns / 1ps

module stop_and_wait_arq_link_core_test;
  import sawl_pkg::*;

  localparam int SETTLE = 40;

  typedef struct {
    logic [2:0]  req;
    logic [7:0]  plen;
    logic [15:0] pcrc;
    logic        rok;
    logic [47:0] src;
    logic [7:0]  rlen;
    logic [1:0]  kind;
    logic [15:0] rid;
    logic [7:0]  rsize;
    logic [15:0] rchk;
  } link_req_t;

  typedef struct {
    link_req_t rq;
    logic      has_act;
    act_t      act;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_payload_len = '0;
  logic [15:0] in_payload_crc = '0;
  logic        in_radio_ok = 1'b0;
  logic [47:0] in_source_address = '0;
  logic [7:0]  in_received_len = '0;
  logic [1:0]  in_rx_kind = '0;
  logic [15:0] in_rx_id = '0;
  logic [7:0]  in_rx_payload_size = '0;
  logic [15:0] in_rx_checksum = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_action;
  logic [15:0] out_pkt_id;
  logic [7:0]  out_pkt_len;
  logic [15:0] out_pkt_checksum;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  stop_and_wait_arq_link_core uut (.*);

  always #10 clk = ~clk;

  // link state mirror
  logic [47:0] m_peer;
  logic [3:0]  m_retry;
  logic [15:0] m_tmo;
  logic [15:0] m_life;
  logic [7:0]  m_maxlen;
  mode_t       m_mode;
  logic [15:0] m_next_id;
  logic [3:0]  m_attempts;
  logic [15:0] m_wait;
  logic [31:0] m_now;
  logic [15:0] m_out_id;
  logic [7:0]  m_out_len;
  logic [15:0] m_out_chk;
  logic        memo_ok [MemoEntriesDef];
  logic [15:0] memo_id [MemoEntriesDef];
  logic [31:0] memo_stamp [MemoEntriesDef];
  int          memo_slot;

  res_t pending_results[$];
  int   errors = 0;
  bit   sender_idle_on = 1'b1;
  bit   sink_stall_on = 1'b1;

  function automatic void add_result(act_t a, logic [15:0] id, logic [7:0] len,
                                     logic [15:0] chk, logic lst);
    res_t r;
    r.action = a;
    r.pkt_id = id;
    r.pkt_len = len;
    r.pkt_checksum = chk;
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic bit memo_seen(logic [15:0] id);
    logic [31:0] age;
    for (int i = 0; i < MemoEntriesDef; i++) begin
      age = m_now - memo_stamp[i];
      if (memo_ok[i] && age < {16'd0, m_life} && memo_id[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void link_step(link_req_t q);
    case (q.req)
      REQ_SEND: begin
        if (m_mode != MODE_IDLE || q.plen > m_maxlen) begin
          add_result(ACT_REJECT, 0, 0, 0, 1);
        end else begin
          m_next_id = m_next_id + 16'd1;
          if (m_next_id == 16'd0) m_next_id = 16'd1;
          m_out_id = m_next_id;
          m_out_len = q.plen;
          m_out_chk = q.pcrc;
          m_attempts = 0;
          m_mode = MODE_TX_MSG;
          add_result(ACT_TX_MSG, m_out_id, m_out_len, m_out_chk, 1);
        end
      end
      REQ_PING: begin
        if (m_mode != MODE_IDLE) begin
          add_result(ACT_REJECT, 0, 0, 0, 1);
        end else begin
          m_mode = MODE_TX_PING;
          add_result(ACT_TX_PING, 0, 0, 0, 1);
        end
      end
      REQ_RADIO: begin
        if (m_mode == MODE_TX_MSG) begin
          if (q.rok) begin
            m_mode = MODE_WAIT_ACK;
            m_wait = 0;
          end else begin
            m_mode = MODE_IDLE;
            add_result(ACT_SEND_FAIL, m_out_id, 0, 0, 1);
          end
        end else if (m_mode == MODE_TX_ACK || m_mode == MODE_TX_PING) begin
          m_mode = MODE_IDLE;
        end
      end
      REQ_RX: begin
        if (q.src != m_peer) begin
          add_result(ACT_DROP, 0, 0, 0, 1);
        end else if (m_mode == MODE_WAIT_ACK) begin
          if (q.rlen >= HeaderBytesDef && q.kind == KIND_ACK && q.rid == m_out_id) begin
            m_mode = MODE_IDLE;
            add_result(ACT_SEND_OK, m_out_id, 0, 0, 1);
          end else begin
            add_result(ACT_DROP, 0, 0, 0, 1);
          end
        end else if (m_mode != MODE_IDLE || q.rlen < HeaderBytesDef) begin
          add_result(ACT_DROP, 0, 0, 0, 1);
        end else if (q.kind == KIND_PING) begin
          add_result(ACT_PING_SEEN, 0, 0, 0, 1);
        end else if (q.kind != KIND_MSG || {1'b0, q.rlen} != HeaderBytesDef + q.rsize
                     || q.pcrc != q.rchk) begin
          add_result(ACT_DROP, 0, 0, 0, 1);
        end else begin
          m_mode = MODE_TX_ACK;
          if (memo_seen(q.rid)) begin
            add_result(ACT_TX_ACK, q.rid, 0, 0, 1);
          end else begin
            add_result(ACT_TX_ACK, q.rid, 0, 0, 0);
            add_result(ACT_DELIVER, q.rid, q.rsize, 0, 1);
            memo_ok[memo_slot] = 1'b1;
            memo_id[memo_slot] = q.rid;
            memo_stamp[memo_slot] = m_now;
            memo_slot = (memo_slot + 1) % MemoEntriesDef;
          end
        end
      end
      REQ_TICK: begin
        m_now = m_now + 32'd1;
        if (m_mode == MODE_WAIT_ACK) begin
          m_wait = m_wait + 16'd1;
          if (m_wait >= m_tmo) begin
            m_wait = 0;
            if (m_attempts < m_retry) begin
              m_attempts = m_attempts + 4'd1;
              m_mode = MODE_TX_MSG;
              add_result(ACT_TX_MSG, m_out_id, m_out_len, m_out_chk, 1);
            end else begin
              m_mode = MODE_IDLE;
              add_result(ACT_SEND_FAIL, m_out_id, 0, 0, 1);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic link_req_t rx_req(logic [47:0] src, logic [7:0] rlen, logic [1:0] kind,
                                       logic [15:0] rid, logic [7:0] rsize,
                                       logic [15:0] pcrc, logic [15:0] rchk);
    link_req_t q;
    q = '{default: '0};
    q.req = REQ_RX;
    q.src = src;
    q.rlen = rlen;
    q.kind = kind;
    q.rid = rid;
    q.rsize = rsize;
    q.pcrc = pcrc;
    q.rchk = rchk;
    return q;
  endfunction

  function automatic link_req_t ctl_req(logic [2:0] req, logic [7:0] plen,
                                        logic [15:0] pcrc, logic rok);
    link_req_t q;
    q = '{default: '0};
    q.req = req;
    q.plen = plen;
    q.pcrc = pcrc;
    q.rok = rok;
    return q;
  endfunction

  function automatic link_req_t random_req();
    link_req_t q;
    int r;
    q.req = REQ_TICK;
    q.plen = 8'($urandom);
    q.pcrc = 16'($urandom);
    q.rok = 1'($urandom);
    q.src = {16'($urandom), 32'($urandom)};
    q.rlen = 8'($urandom_range(0, 250));
    q.kind = 2'($urandom_range(0, 2));
    q.rid = 16'($urandom);
    q.rsize = 8'($urandom);
    q.rchk = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 14) begin
      q.req = REQ_SEND;
      if ($urandom_range(0, 4) != 0)
        q.plen = 8'($urandom_range(0, (m_maxlen > 245) ? 255 : m_maxlen + 10));
    end else if (r < 19) begin
      q.req = REQ_PING;
    end else if (r < 40) begin
      q.req = REQ_RADIO;
      q.rok = ($urandom_range(0, 9) != 0);
    end else if (r < 70) begin
      q.req = REQ_RX;
      if ($urandom_range(0, 99) < 85) begin
        q.src = m_peer;
        if (m_mode == MODE_WAIT_ACK) begin
          q.kind = KIND_ACK;
          if ($urandom_range(0, 4) != 0) q.rid = m_out_id;
          q.rlen = 8'($urandom_range(4, 250));
        end else if ($urandom_range(0, 9) < 8) begin
          q.kind = ($urandom_range(0, 9) == 0) ? KIND_PING : KIND_MSG;
          q.rid = 16'($urandom_range(0, 11));
          q.rsize = 8'($urandom_range(0, 244));
          q.rlen = q.rsize + 8'(HeaderBytesDef);
          if ($urandom_range(0, 19) != 0) q.rchk = q.pcrc;
        end
      end
    end else if (r < 97) begin
      q.req = REQ_TICK;
    end else begin
      q.req = 3'($urandom_range(5, 7));
    end
    return q;
  endfunction

  task automatic send_req(link_req_t q, output int n_new, output act_t first_act);
    int idx;
    @(negedge clk);
    in_valid = 1'b1;
    in_req_type = q.req;
    in_payload_len = q.plen;
    in_payload_crc = q.pcrc;
    in_radio_ok = q.rok;
    in_source_address = q.src;
    in_received_len = q.rlen;
    in_rx_kind = q.kind;
    in_rx_id = q.rid;
    in_rx_payload_size = q.rsize;
    in_rx_checksum = q.rchk;
    do @(posedge clk); while (!in_ready);
    idx = pending_results.size();
    link_step(q);
    n_new = pending_results.size() - idx;
    first_act = (n_new > 0) ? pending_results[idx].action : ACT_DROP;
    if (sender_idle_on) begin
      int r;
      int gap;
      r = $urandom_range(0, 99);
      gap = (r < 55) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(reg_addr_t a, logic [63:0] v);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {a, 3'b000};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (a)
      ADDR_PEER:      m_peer = v[47:0];
      ADDR_RETRY:     m_retry = v[3:0];
      ADDR_ACK_TMO:   m_tmo = v[15:0];
      ADDR_MEMO_LIFE: m_life = v[15:0];
      ADDR_MAX_LEN:   m_maxlen = v[7:0];
      ADDR_ID_SEED:   m_next_id = v[15:0];
      default: ;
    endcase
  endtask

  // result sink with random stalls
  int stall_left = 0;
  always @(negedge clk) begin
    if (!sink_stall_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        stall_left <= $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= (r >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: action %0d id %0d", $time, out_action,
                 out_pkt_id);
      end else begin
        res_t e;
        e = pending_results.pop_front();
        if (out_action !== e.action || out_pkt_id !== e.pkt_id || out_pkt_len !== e.pkt_len
            || out_pkt_checksum !== e.pkt_checksum || out_last !== e.last) begin
          errors++;
          $display("%0t: mismatch exp act %0d id %0d len %0d chk %h last %0d", $time,
                   e.action, e.pkt_id, e.pkt_len, e.pkt_checksum, e.last);
          $display("%0t:          got act %0d id %0d len %0d chk %h last %0d", $time,
                   out_action, out_pkt_id, out_pkt_len, out_pkt_checksum, out_last);
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    table_row_t rows[$];
    link_req_t q;
    int n_new;
    act_t first_act;
    m_peer = '0;
    m_retry = RetryRst;
    m_tmo = AckTmoRst;
    m_life = MemoLifeRst;
    m_maxlen = MaxLenRst;
    m_mode = MODE_IDLE;
    m_next_id = IdSeedRst;
    m_attempts = '0;
    m_wait = '0;
    m_now = '0;
    m_out_id = '0;
    m_out_len = '0;
    m_out_chk = '0;
    memo_slot = 0;
    for (int i = 0; i < MemoEntriesDef; i++) begin
      memo_ok[i] = 1'b0;
      memo_id[i] = '0;
      memo_stamp[i] = '0;
    end

    rows.push_back('{ctl_req(REQ_PING, 0, 0, 0), 1, ACT_TX_PING});
    rows.push_back('{ctl_req(REQ_SEND, 5, 0, 0), 1, ACT_REJECT});
    rows.push_back('{ctl_req(REQ_PING, 0, 0, 0), 1, ACT_REJECT});
    rows.push_back('{ctl_req(REQ_RADIO, 0, 0, 1), 0, ACT_DROP});
    rows.push_back('{ctl_req(REQ_SEND, 255, 16'hFFFF, 0), 1, ACT_REJECT});
    rows.push_back('{ctl_req(REQ_SEND, 0, 16'hFFFF, 0), 1, ACT_TX_MSG});
    rows.push_back('{rx_req(0, 6, KIND_PING, 0, 0, 0, 0), 1, ACT_DROP});
    rows.push_back('{ctl_req(REQ_RADIO, 0, 0, 0), 1, ACT_SEND_FAIL});
    rows.push_back('{ctl_req(REQ_SEND, 200, 16'h0000, 0), 1, ACT_TX_MSG});
    rows.push_back('{ctl_req(REQ_RADIO, 0, 0, 1), 0, ACT_DROP});
    rows.push_back('{rx_req('1, 6, KIND_ACK, 10002, 0, 0, 0), 1, ACT_DROP});
    rows.push_back('{rx_req(0, 6, KIND_ACK, 10001, 0, 0, 0), 1, ACT_DROP});
    rows.push_back('{ctl_req(REQ_TICK, 0, 0, 0), 0, ACT_DROP});
    rows.push_back('{rx_req(0, 6, KIND_ACK, 10002, 0, 0, 0), 1, ACT_SEND_OK});
    rows.push_back('{rx_req(0, 5, KIND_MSG, 1, 0, 0, 0), 1, ACT_DROP});
    rows.push_back('{rx_req(0, 6, KIND_PING, 0, 0, 0, 0), 1, ACT_PING_SEEN});
    rows.push_back('{ctl_req(REQ_RADIO, 0, 0, 1), 0, ACT_DROP});
    rows.push_back('{rx_req(0, 16, KIND_MSG, 16'hFFFF, 10, 16'h1234, 16'h1234), 1, ACT_TX_ACK});
    rows.push_back('{ctl_req(REQ_RADIO, 0, 0, 0), 0, ACT_DROP});
    rows.push_back('{rx_req(0, 16, KIND_MSG, 16'hFFFF, 10, 16'h1234, 16'h1234), 1, ACT_TX_ACK});
    rows.push_back('{ctl_req(REQ_RADIO, 0, 0, 1), 0, ACT_DROP});
    rows.push_back('{rx_req(0, 6, 2'd3, 7, 0, 0, 0), 1, ACT_DROP});
    rows.push_back('{rx_req(0, 250, KIND_MSG, 7, 255, 0, 0), 1, ACT_DROP});
    rows.push_back('{rx_req(0, 6, KIND_MSG, 7, 0, 16'h00FF, 16'hFF00), 1, ACT_DROP});
    rows.push_back('{rx_req(0, 250, KIND_ACK, 10002, 244, 0, 0), 1, ACT_DROP});
    rows.push_back('{ctl_req(3'd7, 0, 0, 0), 0, ACT_DROP});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send_req(rows[i].rq, n_new, first_act);
      if (rows[i].has_act && (n_new == 0 || first_act != rows[i].act)) begin
        errors++;
        $display("%0t: table row %0d exp action %0d got %0d (results %0d)", $time, i,
                 rows[i].act, first_act, n_new);
      end else if (!rows[i].has_act && n_new != 0) begin
        errors++;
        $display("%0t: table row %0d exp no result got action %0d", $time, i, first_act);
      end
    end

    for (int p = 0; p < 8; p++) begin
      drain();
      reg_write(ADDR_PEER, (p == 0) ? 64'd0 : (p == 1) ? 64'hFFFF_FFFF_FFFF
                                          : {32'($urandom), 32'($urandom)});
      reg_write(ADDR_RETRY, (p == 0) ? 0 : (p == 1) ? 15 : $urandom_range(0, 15));
      reg_write(ADDR_ACK_TMO, (p == 7) ? 65535 : (p == 1) ? 1 : $urandom_range(1, 8));
      reg_write(ADDR_MEMO_LIFE, (p == 0) ? 0 : (p == 1) ? 65535 : $urandom_range(1, 60));
      reg_write(ADDR_MAX_LEN, (p == 0) ? 0 : (p == 1) ? 240 : $urandom_range(0, 240));
      reg_write(ADDR_ID_SEED, (p == 0) ? 65535 : (p == 1) ? 1 : $urandom_range(1, 65535));
      sender_idle_on = (p % 3 != 2);
      sink_stall_on = (p % 4 != 3);
      for (int n = 0; n < 118; n++) begin
        q = random_req();
        send_req(q, n_new, first_act);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
